>>> design/css_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cursor sequence store.
// No dependencies; every other file of the block imports this package.
package css_pkg;

	localparam int CAPACITY_DEF   = 32;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int COUNT_W        = 6;

	typedef enum logic [2:0] {
		OP_QUERY   = 3'd0,
		OP_START   = 3'd1,
		OP_ADVANCE = 3'd2,
		OP_INSERT  = 3'd3,
		OP_ATTACH  = 3'd4,
		OP_REMOVE  = 3'd5
	} css_op_t;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_NO_CUR = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic [VALUE_W-1:0] value;
	} css_in_t;

	typedef struct packed {
		logic [VALUE_W-1:0] current_value;
		logic               has_current;
		logic [COUNT_W-1:0] count;
		logic [1:0]         status;
	} css_out_t;

	// Broadcast to every cell: open a gap and load, or close the gap.
	typedef struct packed {
		logic ins;
		logic rem;
	} css_ctl_t;

endpackage

>>> design/css_cell.sv
`timescale 1ns / 1ps
// One storage cell of the entry chain: holds one word and can take the word
// of its lower or upper neighbor. Depends on css_pkg.
module css_cell #(
	parameter int WORD_WIDTH = css_pkg::WORD_WIDTH_DEF,
	parameter int CNT_W      = 6,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  css_pkg::css_ctl_t     ctl,
	input  logic [CNT_W-1:0]      pos,
	input  logic [WORD_WIDTH-1:0] word,
	input  logic [WORD_WIDTH-1:0] lower,
	input  logic [WORD_WIDTH-1:0] upper,
	output logic [WORD_WIDTH-1:0] entry
);
	import css_pkg::*;

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

	logic [WORD_WIDTH-1:0] entry_q;

	// On insert the cell at the gap loads the new word and every cell above
	// it takes its lower neighbor. On remove every cell from the gap upward
	// takes its upper neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_POS == pos) begin
				entry_q <= word;
			end else if (MY_POS > pos) begin
				entry_q <= lower;
			end
		end else if (ctl.rem) begin
			if (MY_POS >= pos) begin
				entry_q <= upper;
			end
		end
	end

	assign entry = entry_q;

endmodule

>>> design/cursor_sequence_store_top.sv
`timescale 1ns / 1ps
// Top level of the cursor sequence store: control, cursor and count, the
// chain of css_cell entries and the result register. Depends on css_pkg.
//
//  channel | handshake        | payload              | direction
//  --------+------------------+----------------------+----------
//  command | start / busy     | item   (css_in_t)    | in
//  result  | done (one cycle) | result (css_out_t)   | out
//
// Every command passes the cell chain once; busy stays low, so a new
// command may follow in every cycle. A command accepted at a clock edge
// updates the cursor, the count, the cells and status_s1; the result stage
// then selects the entry under the cursor from the chain and registers it
// in result_s2, with done_s2, where the receiver takes the result beat.
// The receiver cannot stall; results leave at the command rate.
// Reset clears the cursor, the count and the result strobes. The entry
// cells are not reset: only positions below the count are ever read, and
// each of those has been written by an insert or attach.
module cursor_sequence_store_top #(
	parameter int CAPACITY   = css_pkg::CAPACITY_DEF,
	parameter int WORD_WIDTH = css_pkg::WORD_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  css_pkg::css_in_t item,
	output logic             done,
	output css_pkg::css_out_t result
);
	import css_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]      cursor_q, count_q;
	logic [CNT_W-1:0]      cursor_d, count_d, pos_d;
	logic [1:0]            status_d;
	logic [1:0]            status_s1;
	logic                  valid_s1;
	css_out_t              result_s2;
	logic                  done_s2;
	css_ctl_t              ctl;
	logic                  accept;
	logic                  has_cur;
	logic                  full;
	logic [63:0]           value_ext;
	logic [WORD_WIDTH-1:0] word;
	logic [WORD_WIDTH-1:0] cells [CAPACITY];

	// The chain never has to refuse a command.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign value_ext = 64'(item.value);
	assign word      = value_ext[WORD_WIDTH-1:0];

	assign has_cur = cursor_q < count_q;
	assign full    = count_q == CAP_CNT;

	// Decode one command into the next cursor and count and the gap position
	// that the cells compare against.
	always_comb begin
		cursor_d = cursor_q;
		count_d  = count_q;
		pos_d    = cursor_q;
		status_d = ST_DONE;
		ctl      = '0;
		case (css_op_t'(item.op))
			OP_START: begin
				cursor_d = '0;
			end
			OP_ADVANCE: begin
				if (has_cur) begin
					cursor_d = cursor_q + 1'b1;
				end
			end
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					// With no current entry the word goes in at the front.
					pos_d    = has_cur ? cursor_q : '0;
					cursor_d = pos_d;
					count_d  = count_q + 1'b1;
					ctl.ins  = 1'b1;
				end
			end
			OP_ATTACH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					// With no current entry the word goes after the last one,
					// which is the front when the store is empty.
					pos_d    = has_cur ? cursor_q + 1'b1 : count_q;
					cursor_d = pos_d;
					count_d  = count_q + 1'b1;
					ctl.ins  = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!has_cur) begin
					status_d = ST_NO_CUR;
				end else begin
					count_d = count_q - 1'b1;
					ctl.rem = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				cursor_q <= cursor_d;
				count_q  <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
		end
	end

	// The chain of entry cells; the ends feed back their own word as the missing
	// neighbor. Only the top cell ever takes it, on a remove, keeping its word.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		css_cell #(
			.WORD_WIDTH(WORD_WIDTH),
			.CNT_W     (CNT_W),
			.IDX       (i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.pos  (pos_d),
			.word (word),
			.lower(cells[(i == 0) ? i : i - 1]),
			.upper(cells[(i == CAPACITY - 1) ? i : i + 1]),
			.entry(cells[i])
		);
	end

	// Result stage: the state left by the previous command is read here.
	logic [IDX_W-1:0] sel_idx;
	logic [63:0]      sel_ext;
	logic [15:0]      count_ext;

	assign sel_idx   = cursor_q[IDX_W-1:0];
	assign sel_ext   = has_cur ? 64'(cells[sel_idx]) : 64'd0;
	assign count_ext = 16'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2.current_value <= sel_ext[VALUE_W-1:0];
			result_s2.has_current   <= has_cur;
			result_s2.count         <= count_ext[COUNT_W-1:0];
			result_s2.status        <= status_s1;
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

endmodule

>>> design/css_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the cursor sequence store and the bind that
// attaches them to the top level. Depends on css_pkg.
module css_checker #(
	parameter int CAPACITY = css_pkg::CAPACITY_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input css_pkg::css_in_t  item,
	input logic              done,
	input css_pkg::css_out_t result
);
	import css_pkg::*;

	localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

	// Every result beat comes, through the result stage, from an accepted command beat.
	a_done_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start, 2) && !$past(busy, 2)))
		else $error("result beat without a command beat");

	// No current entry means the value reads as zero.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.has_current) |-> (result.current_value == '0))
		else $error("value shown without a current entry");

	// A rejected insert or attach only happens on a full store.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (result.count == CAP_COUNT))
		else $error("insert rejected below capacity");

	// A rejected remove only happens with no current entry.
	a_no_cur: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_NO_CUR) |-> !result.has_current)
		else $error("remove rejected with a current entry");

	// A current entry implies the store is not empty.
	a_cur_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.has_current) |-> (result.count != '0))
		else $error("current entry in an empty store");

endmodule

bind cursor_sequence_store_top css_checker #(
	.CAPACITY(CAPACITY)
) u_css_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.item  (item),
	.done  (done),
	.result(result)
);

>>> test/cursor_sequence_store_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cursor_sequence_store_top: a directed table, then random beats.
// Every result is checked against a local mirror of the store, cursor and count.
// Depends on css_pkg and the cursor_sequence_store_top RTL.
module cursor_sequence_store_top_tb;
	import css_pkg::*;

	localparam int CAP           = CAPACITY_DEF;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;

	// Op codes outside the enum. The block must treat them as a query.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// One row of the directed table. A row is sent reps times, and its value is
	// XORed with the repeat index. When known is set, the typed result in want
	// is the expectation. Otherwise the mirror supplies the expectation.
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] value;
		int          reps;
		bit          known;
		css_out_t    want;
	} plan_row_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	css_in_t  item;
	logic     done;
	css_out_t result;

	// These travel alongside item, so the monitor sees them on the same edge.
	logic     item_known;
	css_out_t item_want;

	// Mirror of the block state.
	logic [31:0] mirror_words [CAP];
	int          mirror_count;
	int          mirror_cursor;

	css_out_t    views_due [$];
	plan_row_t   plan [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          beats_seen = 0;

	cursor_sequence_store_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run. A correct run ends well before CYCLE_LIMIT,
	// so reaching this count means the block has hung.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("cursor_sequence_store_top test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at result %0d: %s got %h expected %h", beats_seen, what, got, want);
		mismatches++;
	endtask

	// Apply one command to the mirror and return the view of the state after it.
	// Each operation works on the mirror in the same way the store does.
	task automatic apply_to_mirror(input css_in_t cmd, output css_out_t view);
		logic [1:0] status;
		int         pos;
		status = ST_DONE;
		case (cmd.op)
			OP_START: begin
				mirror_cursor = 0;
			end
			OP_ADVANCE: begin
				// The cursor saturates at the count.
				if (mirror_cursor < mirror_count)
					mirror_cursor++;
			end
			OP_INSERT: begin
				if (mirror_count >= CAP) begin
					status = ST_FULL;
				end else begin
					// With no current entry, the new word goes to the front.
					if (mirror_cursor >= mirror_count)
						mirror_cursor = 0;
					for (int i = mirror_count; i > mirror_cursor; i--)
						mirror_words[i] = mirror_words[i-1];
					mirror_words[mirror_cursor] = cmd.value;
					mirror_count++;
				end
			end
			OP_ATTACH: begin
				if (mirror_count >= CAP) begin
					status = ST_FULL;
				end else begin
					// With no current entry, the new word goes after the last one.
					if (mirror_count == 0)
						pos = 0;
					else if (mirror_cursor >= mirror_count)
						pos = mirror_count;
					else
						pos = mirror_cursor + 1;
					for (int i = mirror_count; i > pos; i--)
						mirror_words[i] = mirror_words[i-1];
					mirror_words[pos] = cmd.value;
					mirror_cursor = pos;
					mirror_count++;
				end
			end
			OP_REMOVE: begin
				if (mirror_cursor >= mirror_count) begin
					status = ST_NO_CUR;
				end else begin
					for (int i = mirror_cursor; i + 1 < mirror_count; i++)
						mirror_words[i] = mirror_words[i+1];
					mirror_count--;
				end
			end
			default: begin
			end
		endcase
		view.has_current   = (mirror_cursor < mirror_count);
		view.current_value = view.has_current ? mirror_words[mirror_cursor] : '0;
		view.count         = COUNT_W'(mirror_count);
		view.status        = status;
	endtask

	// Monitor and checker. All reads happen at the rising edge, before the
	// nonblocking updates of that edge land. The values seen are the ones that
	// the block samples on the same edge.
	always @(posedge clk) begin
		css_out_t predicted;
		css_out_t due;
		if (arst_n) begin
			if (done) begin
				beats_seen++;
				if (views_due.size() == 0) begin
					report_mismatch("result with nothing due", 64'(result), '0);
				end else begin
					due = views_due.pop_front();
					if (result.current_value !== due.current_value)
						report_mismatch("current_value", 64'(result.current_value),
							64'(due.current_value));
					if (result.has_current !== due.has_current)
						report_mismatch("has_current", 64'(result.has_current),
							64'(due.has_current));
					if (result.count !== due.count)
						report_mismatch("count", 64'(result.count), 64'(due.count));
					if (result.status !== due.status)
						report_mismatch("status", 64'(result.status), 64'(due.status));
				end
			end
			if (start && !busy) begin
				apply_to_mirror(item, predicted);
				views_due.push_back(item_known ? item_want : predicted);
			end
		end
	end

	task automatic add_step(input logic [2:0] op, input logic [31:0] value, input int reps);
		plan_row_t row;
		row.op    = op;
		row.value = value;
		row.reps  = reps;
		row.known = 1'b0;
		row.want  = '0;
		plan.push_back(row);
	endtask

	task automatic add_known(input logic [2:0] op, input logic [31:0] value,
			input logic [31:0] want_value, input logic want_has,
			input int want_count, input logic [1:0] want_status);
		plan_row_t row;
		row.op                 = op;
		row.value              = value;
		row.reps               = 1;
		row.known              = 1'b1;
		row.want.current_value = want_value;
		row.want.has_current   = want_has;
		row.want.count         = COUNT_W'(want_count);
		row.want.status        = want_status;
		plan.push_back(row);
	endtask

	// Most gaps are short and a few are long. In a burst stretch there are none.
	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 25);
	endfunction

	// Send one command beat. When the gap is zero, start stays high, so that
	// only one nonblocking write to start can fall in any time step.
	task automatic send_beat(input css_in_t cmd, input bit known, input css_out_t want,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= cmd;
		item_known <= known;
		item_want  <= want;
		start      <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		css_in_t cmd;
		bit      grow;
		bit      burst;
		int      phase_left;
		int      burst_left;
		int      r;

		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		item_known = 1'b0;
		item_want  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. The typed rows can be read off by hand: the empty store
		// after reset, the first two words, and a remove with no current entry.
		add_known(OP_QUERY,   32'h0000_0000, 32'h0000_0000, 1'b0, 0, ST_DONE);
		add_known(OP_REMOVE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0, ST_NO_CUR);
		add_known(OP_ADVANCE, 32'h0000_0000, 32'h0000_0000, 1'b0, 0, ST_DONE);
		add_known(OP_ATTACH,  32'h0000_0000, 32'h0000_0000, 1'b1, 1, ST_DONE);
		add_known(OP_INSERT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 2, ST_DONE);
		// Walk off the end; the last advance saturates.
		add_step(OP_ADVANCE, 32'h0000_0000, 3);
		// Insert with no current entry goes to the front.
		add_step(OP_INSERT,  32'h8000_0000, 1);
		add_step(OP_ADVANCE, 32'h1234_5678, 3);
		// Attach with no current entry goes after the last entry.
		add_step(OP_ATTACH,  32'h0000_0001, 1);
		add_step(OP_SPARE_LO, 32'hDEAD_BEEF, 1);
		add_step(OP_SPARE_HI, 32'hFFFF_FFFF, 1);
		add_step(OP_START,   32'h0000_0000, 1);
		add_step(OP_ADVANCE, 32'h0000_0000, 1);
		// Remove and attach in the middle of the store.
		add_step(OP_REMOVE,  32'h0000_0000, 1);
		add_step(OP_ATTACH,  32'h5A5A_5A5A, 1);
		// Removing the last entry leaves no current entry.
		add_step(OP_REMOVE,  32'h0000_0000, 2);
		add_known(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, 2, ST_NO_CUR);
		// Fill the store to capacity. The last attach is rejected as full.
		add_step(OP_START,   32'h0000_0000, 1);
		add_step(OP_ATTACH,  32'hC300_0000, CAP - 1);
		add_step(OP_INSERT,  32'h7FFF_FFFF, 1);
		add_step(OP_START,   32'h0000_0000, 1);
		add_step(OP_REMOVE,  32'h0000_0000, 2);
		add_step(OP_INSERT,  32'hAAAA_5555, 1);

		foreach (plan[n]) begin
			for (int k = 0; k < plan[n].reps; k++) begin
				cmd.op    = plan[n].op;
				cmd.value = plan[n].value ^ k;
				send_beat(cmd, plan[n].known, plan[n].want, pick_gap(1'b0));
			end
		end

		// Random part. Grow and shrink phases alternate, so that the store swings
		// between empty and full many times, while the cursor moves through it.
		grow       = 1'b1;
		burst      = 1'b0;
		phase_left = $urandom_range(40, 150);
		burst_left = 64;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				grow       = !grow;
				phase_left = $urandom_range(40, 150);
			end
			if (burst_left == 0) begin
				burst      = ($urandom_range(0, 3) == 0);
				burst_left = $urandom_range(20, 80);
			end
			phase_left--;
			burst_left--;

			r = $urandom_range(0, 99);
			if (r < (grow ? 30 : 10))
				cmd.op = OP_INSERT;
			else if (r < (grow ? 60 : 20))
				cmd.op = OP_ATTACH;
			else if (r < (grow ? 70 : 60))
				cmd.op = OP_REMOVE;
			else if (r < 82)
				cmd.op = OP_ADVANCE;
			else if (r < 90)
				cmd.op = OP_START;
			else if (r < 95)
				cmd.op = OP_QUERY;
			else
				cmd.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;

			r = $urandom_range(0, 7);
			if (r == 0)
				cmd.value = 32'h0000_0000;
			else if (r == 1)
				cmd.value = 32'hFFFF_FFFF;
			else
				cmd.value = $urandom;

			send_beat(cmd, 1'b0, '0, pick_gap(burst));
		end

		// Drain. The idle edge lets the monitor record the last beat before the
		// queue is looked at. Then wait for every due result, and SETTLE_CYCLES more.
		start <= 1'b0;
		@(posedge clk);
		while (views_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("cursor_sequence_store_top test passed");
		else
			$display("cursor_sequence_store_top test failed");
		$finish;
	end

endmodule

>>> cursor_sequence_store_top.f
design/css_pkg.sv
design/css_cell.sv
design/cursor_sequence_store_top.sv
design/css_checker.sv
test/cursor_sequence_store_top_tb.sv
